>>> hw/rtl/afc_pkg.sv
// Shared types and constants for the box versus frustum cull core.
`timescale 1ns / 1ps

package afc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 16;
    localparam int PROD_W     = 2 * COORD_W;
    // three products and the scaled d term never exceed 2^32 in magnitude
    localparam int DIST_W     = PROD_W + 2;
    localparam int D_SHIFT    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DIST_W-1:0]  dist_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    // d sits in the top field, a in the bottom one
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] a;
    } plane_t;

    localparam cfg_idx_t REG_PLANE_LEFT   = 3'd0;
    localparam cfg_idx_t REG_PLANE_RIGHT  = 3'd1;
    localparam cfg_idx_t REG_PLANE_BOTTOM = 3'd2;
    localparam cfg_idx_t REG_PLANE_TOP    = 3'd3;
    localparam cfg_idx_t REG_PLANE_NEAR   = 3'd4;
    localparam cfg_idx_t REG_PLANE_FAR    = 3'd5;

endpackage

>>> hw/rtl/aabb_frustum_cull_core.sv
// Axis-aligned box versus six-plane frustum cull, four register stages.
//
// Usage:
//   Boxes enter on the in channel (in_valid/in_ready) as min and max
//   corners, signed 16-bit per axis. Each box gives one result on the out
//   channel (out_valid/out_ready): intersects (positive vertex test passes
//   on every plane) and fully_inside (all eight corners strictly inside).
//   Planes are loaded through cfg_we/cfg_index/cfg_data while no box is in
//   flight; an index above five is dropped.
//   Pipeline: the result is registered in turn after vertex select, products,
//   plane sums and compare, and flag merge.
//   Throughput: one box per cycle while out_ready does not stall the pipe;
//   each of the 36 16x16 multipliers is used once per box.
//   Stall: all stages advance together; while out_valid is high and
//   out_ready low, the whole pipe holds and in_ready is low.
//   Reset: the pipe empties and all planes clear to zero, so a box then
//   reads intersects = 1, fully_inside = 0.
`timescale 1ns / 1ps

module aabb_frustum_cull_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [afc_pkg::COORD_W-1:0]  min_x,
    input  logic signed [afc_pkg::COORD_W-1:0]  min_y,
    input  logic signed [afc_pkg::COORD_W-1:0]  min_z,
    input  logic signed [afc_pkg::COORD_W-1:0]  max_x,
    input  logic signed [afc_pkg::COORD_W-1:0]  max_y,
    input  logic signed [afc_pkg::COORD_W-1:0]  max_z,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                intersects,
    output logic                                fully_inside
);

    afc_pkg::plane_t planes_reg [afc_pkg::NUM_PLANES];

    logic advance;

    // stage 1: chosen vertices
    logic           v1_reg;
    afc_pkg::coord_t pos_reg  [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    afc_pkg::coord_t pos_next [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    afc_pkg::coord_t neg_reg  [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    afc_pkg::coord_t neg_next [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];

    // stage 2: products
    logic           v2_reg;
    afc_pkg::prod_t pprod_reg  [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    afc_pkg::prod_t pprod_next [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    afc_pkg::prod_t nprod_reg  [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    afc_pkg::prod_t nprod_next [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];

    // stage 3: per-plane flags
    logic                            v3_reg;
    logic [afc_pkg::NUM_PLANES-1:0]  hit_reg;
    logic [afc_pkg::NUM_PLANES-1:0]  hit_next;
    logic [afc_pkg::NUM_PLANES-1:0]  ins_reg;
    logic [afc_pkg::NUM_PLANES-1:0]  ins_next;

    // stage 4: result
    logic out_valid_reg;
    logic intersects_reg;
    logic fully_inside_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    assign out_valid    = out_valid_reg;
    assign intersects   = intersects_reg;
    assign fully_inside = fully_inside_reg;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
            begin
                planes_reg[p] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                afc_pkg::REG_PLANE_LEFT:   planes_reg[0] <= afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_RIGHT:  planes_reg[1] <= afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_BOTTOM: planes_reg[2] <= afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_TOP:    planes_reg[3] <= afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_NEAR:   planes_reg[4] <= afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_FAR:    planes_reg[5] <= afc_pkg::plane_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // stage 1 logic: positive vertex by normal sign as given; negative
    // vertex from the true per-axis min/max so inverted boxes still give
    // the minimum over all eight corners
    always_comb
    begin
        afc_pkg::coord_t lo [afc_pkg::NUM_AXES];
        afc_pkg::coord_t hi [afc_pkg::NUM_AXES];
        afc_pkg::coord_t mn [afc_pkg::NUM_AXES];
        afc_pkg::coord_t mx [afc_pkg::NUM_AXES];
        afc_pkg::coord_t co [afc_pkg::NUM_AXES];

        lo[0] = min_x;
        lo[1] = min_y;
        lo[2] = min_z;
        hi[0] = max_x;
        hi[1] = max_y;
        hi[2] = max_z;
        for (int k = 0; k < afc_pkg::NUM_AXES; k++)
        begin
            mn[k] = (lo[k] < hi[k]) ? lo[k] : hi[k];
            mx[k] = (lo[k] < hi[k]) ? hi[k] : lo[k];
        end
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
        begin
            co[0] = planes_reg[p].a;
            co[1] = planes_reg[p].b;
            co[2] = planes_reg[p].c;
            for (int k = 0; k < afc_pkg::NUM_AXES; k++)
            begin
                pos_next[p][k] = (co[k] > 0) ? hi[k] : lo[k];
                neg_next[p][k] = (co[k] > 0) ? mn[k] : mx[k];
            end
        end
    end

    // stage 2 logic: one multiply per axis and vertex
    always_comb
    begin
        afc_pkg::coord_t co [afc_pkg::NUM_AXES];

        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
        begin
            co[0] = planes_reg[p].a;
            co[1] = planes_reg[p].b;
            co[2] = planes_reg[p].c;
            for (int k = 0; k < afc_pkg::NUM_AXES; k++)
            begin
                pprod_next[p][k] = afc_pkg::prod_t'(co[k]) * afc_pkg::prod_t'(pos_reg[p][k]);
                nprod_next[p][k] = afc_pkg::prod_t'(co[k]) * afc_pkg::prod_t'(neg_reg[p][k]);
            end
        end
    end

    // stage 3 logic: plane distances and their signs
    always_comb
    begin
        afc_pkg::dist_t dterm;
        afc_pkg::dist_t dpos;
        afc_pkg::dist_t dneg;

        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
        begin
            dterm = afc_pkg::dist_t'(planes_reg[p].d) <<< afc_pkg::D_SHIFT;
            dpos  = afc_pkg::dist_t'(pprod_reg[p][0]) + afc_pkg::dist_t'(pprod_reg[p][1])
                  + afc_pkg::dist_t'(pprod_reg[p][2]) + dterm;
            dneg  = afc_pkg::dist_t'(nprod_reg[p][0]) + afc_pkg::dist_t'(nprod_reg[p][1])
                  + afc_pkg::dist_t'(nprod_reg[p][2]) + dterm;
            hit_next[p] = !dpos[afc_pkg::DIST_W-1];
            ins_next[p] = (dneg > 0);
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // pipeline payload; hold everything on a stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_reg          <= pos_next;
            neg_reg          <= neg_next;
            pprod_reg        <= pprod_next;
            nprod_reg        <= nprod_next;
            hit_reg          <= hit_next;
            ins_reg          <= ins_next;
            intersects_reg   <= &hit_reg;
            fully_inside_reg <= &ins_reg;
        end
    end

    // a box whose every corner is strictly inside cannot be culled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!fully_inside_reg || intersects_reg))
        else $error("fully_inside set without intersects");

    // a valid item in stage 2 moves one stage per advancing cycle, into stage 3
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && v2_reg) |=> v3_reg)
        else $error("item lost between stage 2 and stage 3");

    // a stalled pipe holds its flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && v3_reg) |=> (v3_reg && $stable(hit_reg) && $stable(ins_reg)))
        else $error("stage 3 changed during stall");

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(intersects_reg)
                                           && $stable(fully_inside_reg)))
        else $error("result changed while stalled");

endmodule
